@@ design/crse_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the catmull-rom spline evaluator
package crse_pkg;

  localparam int unsigned PT_W     = 24;
  localparam int unsigned RES_W    = 32;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned CNT_W    = 9;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned NUM_TAPS = 4;

  localparam logic [CNT_W-1:0] COUNT_RESET = 9'd4;

  // register index, taken from paddr bit 2
  localparam logic REG_POINT_COUNT = 1'b0;

  typedef enum logic [1:0] {
    ACT_WRITE    = 2'd0,
    ACT_POSITION = 2'd1,
    ACT_TANGENT  = 2'd2
  } action_e;

  typedef struct packed {
    logic [1:0]             action;
    logic [IDX_W-1:0]       index;
    logic [FRAC_W-1:0]      fraction;
    logic                   looped;
    logic signed [PT_W-1:0] point_x_in;
    logic signed [PT_W-1:0] point_y_in;
  } req_t;

  typedef struct packed {
    logic signed [RES_W-1:0] result_x;
    logic signed [RES_W-1:0] result_y;
    logic                    error;
  } rsp_t;

  typedef struct packed {
    logic signed [PT_W-1:0] x;
    logic signed [PT_W-1:0] y;
  } point_t;

endpackage

@@ design/crse_point_ram.sv @@
`timescale 1ns / 1ps
// control point table: two mirrored copies, one write port and four registered read ports
module crse_point_ram
  import crse_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  point_t                   wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i [NUM_TAPS],
  output point_t                   rd_data_o [NUM_TAPS]
);

  point_t mem_lo [DEPTH];
  point_t mem_hi [DEPTH];
  point_t rd_data_q [NUM_TAPS];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_lo[wr_addr_i] <= wr_data_i;
      mem_hi[wr_addr_i] <= wr_data_i;
    end
  end

  // taps 0 and 1 from the low copy, taps 2 and 3 from the high copy
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q[0] <= mem_lo[rd_addr_i[0]];
      rd_data_q[1] <= mem_lo[rd_addr_i[1]];
      rd_data_q[2] <= mem_hi[rd_addr_i[2]];
      rd_data_q[3] <= mem_hi[rd_addr_i[3]];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ design/catmull_rom_spline_evaluator.sv @@
`timescale 1ns / 1ps
// catmull-rom spline evaluator top level: index logic, weight pipeline, point table, apb register
//
// channel   dir  handshake                 payload
// request   in   start high, busy low      req_i
// result    out  result_valid_o strobe     result_o
// config    in   apb write, psel/penable   point_count at byte address 0
//
// one request per cycle; busy stays low and each accepted request gives one result strobe
// the pipeline has six stages: index logic and t^2, t^3, weights with the
// table read, the eight point-weight products, the sums, then rounding and saturation
// reset sets point_count to 4 and empties the pipeline; the point table is not cleared
// results cannot be held off and nothing in the block stalls
module catmull_rom_spline_evaluator
  import crse_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 256,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  req_t              req_i,
  output logic              result_valid_o,
  output rsp_t              result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned AW     = $clog2(MAX_POINTS);
  localparam int unsigned IW     = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;
  localparam int unsigned WW     = FRAC_BITS + 3;
  localparam int unsigned PROD_W = PT_W + WW;
  localparam int unsigned SUM_W  = PROD_W + 2;
  localparam int unsigned RAW_W  = 56;
  localparam int unsigned POS_SH = 48 - FRAC_BITS;
  localparam int unsigned TAN_SH = 32 - FRAC_BITS;

  localparam logic signed [RAW_W-1:0] POS_HALF = RAW_W'(1) <<< (POS_SH - 1);
  localparam logic signed [RAW_W-1:0] TAN_HALF = RAW_W'(1) <<< (TAN_SH - 1);
  localparam logic signed [SUM_W-1:0] OUT_HALF = SUM_W'(1) <<< FRAC_BITS;
  localparam logic [IW-1:0]           MAX_W    = IW'(MAX_POINTS);

  // config register

  logic [CNT_W-1:0] count_q, count_d;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[APB_AW-1] == REG_POINT_COUNT);
  assign count_d = pwdata[CNT_W-1:0];
  assign prdata = (paddr[APB_AW-1] == REG_POINT_COUNT) ? APB_DW'(count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RESET;
    end else if (cfg_wr) begin
      count_q <= count_d;
    end
  end

  // stage 0: neighbor indices and t^2

  logic          req_acc;
  action_e       op_in;
  logic [IW-1:0] idx_w, idx_inc, n_w, nm1_w;
  logic [IW-1:0] p0o, p1o, p2o, p3o, p0l, p2l, p3l;
  logic [AW-1:0] addr_d [NUM_TAPS];
  logic          err_d, zero_d;
  logic [31:0]   f2_d;

  assign busy    = 1'b0;
  assign req_acc = start & ~busy;
  assign op_in   = action_e'(req_i.action);
  assign idx_w   = IW'(req_i.index);
  assign idx_inc = idx_w + IW'(1);
  assign f2_d    = 32'(req_i.fraction) * 32'(req_i.fraction);

  always_comb begin
    if (count_q == '0) begin
      n_w = IW'(1);
    end else if (IW'(count_q) > MAX_W) begin
      n_w = MAX_W;
    end else begin
      n_w = IW'(count_q);
    end
  end

  assign nm1_w = n_w - IW'(1);

  // open mode: clamp to the ends
  assign p1o = (idx_inc > nm1_w) ? nm1_w : idx_inc;
  assign p2o = (p1o + IW'(1) > nm1_w) ? nm1_w : p1o + IW'(1);
  assign p3o = (p2o + IW'(1) > nm1_w) ? nm1_w : p2o + IW'(1);
  assign p0o = (p1o != '0) ? p1o - IW'(1) : '0;

  // looped mode: wrap around the point count
  assign p2l = (idx_inc == n_w) ? '0 : idx_inc;
  assign p3l = (p2l + IW'(1) == n_w) ? '0 : p2l + IW'(1);
  assign p0l = (idx_w != '0) ? idx_w - IW'(1) : nm1_w;

  always_comb begin
    err_d  = 1'b0;
    zero_d = 1'b1;
    if (req_i.looped) begin
      addr_d[0] = p0l[AW-1:0];
      addr_d[1] = idx_w[AW-1:0];
      addr_d[2] = p2l[AW-1:0];
      addr_d[3] = p3l[AW-1:0];
    end else begin
      addr_d[0] = p0o[AW-1:0];
      addr_d[1] = p1o[AW-1:0];
      addr_d[2] = p2o[AW-1:0];
      addr_d[3] = p3o[AW-1:0];
    end
    unique case (op_in)
      ACT_WRITE: begin
        err_d     = (idx_w >= MAX_W);
        addr_d[1] = idx_w[AW-1:0];
      end
      ACT_POSITION, ACT_TANGENT: begin
        err_d  = req_i.looped & (idx_w >= n_w);
        zero_d = req_i.looped & (idx_w >= n_w);
      end
      default: begin
        err_d = 1'b1;
      end
    endcase
  end

  // stage 1: t^3

  logic          s1_vld_q;
  action_e       s1_op_q;
  logic          s1_err_q, s1_zero_q;
  logic [AW-1:0] s1_addr_q [NUM_TAPS];
  logic [15:0]   s1_f_q;
  logic [31:0]   s1_f2_q;
  point_t        s1_pt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= req_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      s1_op_q   <= op_in;
      s1_err_q  <= err_d;
      s1_zero_q <= zero_d;
      s1_addr_q <= addr_d;
      s1_f_q    <= req_i.fraction;
      s1_f2_q   <= f2_d;
      s1_pt_q   <= '{x: req_i.point_x_in, y: req_i.point_y_in};
    end
  end

  // stage 2: weights, table access

  logic          s2_vld_q;
  action_e       s2_op_q;
  logic          s2_err_q, s2_zero_q;
  logic [AW-1:0] s2_addr_q [NUM_TAPS];
  logic [15:0]   s2_f_q;
  logic [31:0]   s2_f2_q;
  logic [47:0]   s2_f3_q;
  point_t        s2_pt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      s2_op_q   <= s1_op_q;
      s2_err_q  <= s1_err_q;
      s2_zero_q <= s1_zero_q;
      s2_addr_q <= s1_addr_q;
      s2_f_q    <= s1_f_q;
      s2_f2_q   <= s1_f2_q;
      s2_f3_q   <= 48'(s1_f2_q) * 48'(s1_f_q);
      s2_pt_q   <= s1_pt_q;
    end
  end

  logic signed [RAW_W-1:0] fe, f2e, f3e;
  logic signed [RAW_W-1:0] pos_raw [NUM_TAPS];
  logic signed [RAW_W-1:0] tan_raw [NUM_TAPS];
  logic signed [WW-1:0]    w_d [NUM_TAPS];

  assign fe  = RAW_W'(s2_f_q);
  assign f2e = RAW_W'(s2_f2_q);
  assign f3e = RAW_W'(s2_f3_q);

  // position weights in units of 2^-48
  assign pos_raw[0] = -f3e + (f2e <<< 17) - (fe <<< 32);
  assign pos_raw[1] = RAW_W'(3) * f3e - RAW_W'(5) * (f2e <<< 16) + (RAW_W'(1) <<< 49);
  assign pos_raw[2] = -(RAW_W'(3) * f3e) + (f2e <<< 18) + (fe <<< 32);
  assign pos_raw[3] = f3e - (f2e <<< 16);

  // tangent weights in units of 2^-32
  assign tan_raw[0] = -(RAW_W'(3) * f2e) + (fe <<< 18) - (RAW_W'(1) <<< 32);
  assign tan_raw[1] = RAW_W'(9) * f2e - RAW_W'(10) * (fe <<< 16);
  assign tan_raw[2] = -(RAW_W'(9) * f2e) + (fe <<< 19) + (RAW_W'(1) <<< 32);
  assign tan_raw[3] = RAW_W'(3) * f2e - (fe <<< 17);

  always_comb begin
    for (int k = 0; k < NUM_TAPS; k++) begin
      if (s2_op_q == ACT_POSITION) begin
        w_d[k] = WW'((pos_raw[k] + POS_HALF) >>> POS_SH);
      end else begin
        w_d[k] = WW'((tan_raw[k] + TAN_HALF) >>> TAN_SH);
      end
    end
  end

  logic   tbl_wr;
  point_t rd_pt [NUM_TAPS];

  assign tbl_wr = s2_vld_q & (s2_op_q == ACT_WRITE) & ~s2_err_q;

  crse_point_ram #(
    .DEPTH(MAX_POINTS)
  ) u_point_ram (
    .clk_i    (clk_i),
    .wr_en_i  (tbl_wr),
    .wr_addr_i(s2_addr_q[1]),
    .wr_data_i(s2_pt_q),
    .rd_en_i  (s2_vld_q),
    .rd_addr_i(s2_addr_q),
    .rd_data_o(rd_pt)
  );

  // stage 3: point times weight

  logic                 s3_vld_q, s3_err_q, s3_zero_q;
  logic signed [WW-1:0] s3_w_q [NUM_TAPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_vld_q) begin
      s3_err_q  <= s2_err_q;
      s3_zero_q <= s2_zero_q;
      s3_w_q    <= w_d;
    end
  end

  logic signed [PROD_W-1:0] px_d [NUM_TAPS];
  logic signed [PROD_W-1:0] py_d [NUM_TAPS];

  always_comb begin
    for (int k = 0; k < NUM_TAPS; k++) begin
      px_d[k] = PROD_W'(rd_pt[k].x) * PROD_W'(s3_w_q[k]);
      py_d[k] = PROD_W'(rd_pt[k].y) * PROD_W'(s3_w_q[k]);
    end
  end

  // stage 4: sums

  logic                     s4_vld_q, s4_err_q, s4_zero_q;
  logic signed [PROD_W-1:0] s4_px_q [NUM_TAPS];
  logic signed [PROD_W-1:0] s4_py_q [NUM_TAPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_vld_q) begin
      s4_err_q  <= s3_err_q;
      s4_zero_q <= s3_zero_q;
      s4_px_q   <= px_d;
      s4_py_q   <= py_d;
    end
  end

  logic signed [SUM_W-1:0] sx_d, sy_d;

  assign sx_d = SUM_W'(s4_px_q[0]) + SUM_W'(s4_px_q[1])
              + SUM_W'(s4_px_q[2]) + SUM_W'(s4_px_q[3]);
  assign sy_d = SUM_W'(s4_py_q[0]) + SUM_W'(s4_py_q[1])
              + SUM_W'(s4_py_q[2]) + SUM_W'(s4_py_q[3]);

  // stage 5: halve, round to q24.8, saturate

  logic                    s5_vld_q, s5_err_q, s5_zero_q;
  logic signed [SUM_W-1:0] s5_sx_q, s5_sy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else begin
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_vld_q) begin
      s5_err_q  <= s4_err_q;
      s5_zero_q <= s4_zero_q;
      s5_sx_q   <= sx_d;
      s5_sy_q   <= sy_d;
    end
  end

  function automatic logic signed [RES_W-1:0] sat_res(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    r = (v + OUT_HALF) >>> (FRAC_BITS + 1);
    if (&r[SUM_W-1:RES_W-1] || ~|r[SUM_W-1:RES_W-1]) begin
      sat_res = r[RES_W-1:0];
    end else if (r[SUM_W-1]) begin
      sat_res = {1'b1, {(RES_W-1){1'b0}}};
    end else begin
      sat_res = {1'b0, {(RES_W-1){1'b1}}};
    end
  endfunction

  logic result_valid_q;
  rsp_t result_q, result_d;

  always_comb begin
    result_d.error = s5_err_q;
    if (s5_zero_q) begin
      result_d.result_x = '0;
      result_d.result_y = '0;
    end else begin
      result_d.result_x = sat_res(s5_sx_q);
      result_d.result_y = sat_res(s5_sy_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s5_vld_q) begin
      result_q <= result_d;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |-> ##6 result_valid_o)
    else $error("result strobe missing six cycles after request");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> s5_vld_q == 1'b0 || s4_vld_q == 1'b0 || $past(s5_vld_q))
    else $error("result strobe without a request in the pipeline");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.error) |-> (result_o.result_x == '0 && result_o.result_y == '0))
    else $error("error result with nonzero coordinates");

  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && op_in == ACT_WRITE) |->
      ##6 (result_o.result_x == '0 && result_o.result_y == '0))
    else $error("write request gave nonzero coordinates");

  a_loop_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && req_i.looped && (op_in == ACT_POSITION || op_in == ACT_TANGENT) &&
     idx_w >= n_w) |-> ##6 (result_valid_o && result_o.error))
    else $error("looped segment beyond point count not flagged");
`endif

endmodule
